// ===== src/slot_map_handle_table_core_assert.svh =====
// assertion macros used by the checker file
`ifndef SLOT_MAP_HANDLE_TABLE_CORE_ASSERT_SVH
`define SLOT_MAP_HANDLE_TABLE_CORE_ASSERT_SVH

// clocked check, masked while reset is held
`define SMHT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slot map handle table check failed");

// clocked check that also holds during reset
`define SMHT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("slot map handle table check failed");

`endif

// ===== src/smht_pkg.sv =====
// shared types and constants of the slot map handle table
`timescale 1ns / 1ps

package smht_pkg;

  localparam int unsigned CapacityDefault = 256;

  localparam int unsigned SlotIdW   = 8;
  localparam int unsigned DensePosW = 8;
  localparam int unsigned LiveCntW  = 9;

  typedef enum logic [1:0] {
    ReqCreate = 2'd0,
    ReqRemove = 2'd1,
    ReqLookup = 2'd2
  } smht_req_e;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusFull       = 2'd1,
    StatusLookupMiss = 2'd2,
    StatusRemoveMiss = 2'd3
  } smht_status_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SlotIdW-1:0] slot_id;
  } smht_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SlotIdW-1:0]   result_id;
    logic [DensePosW-1:0] dense_pos;
    logic [LiveCntW-1:0]  live_count;
  } smht_rsp_t;

  typedef struct packed {
    logic rd_en;
    logic pos_we;
    logic idp_we;
    logic nf_we;
  } smht_mem_ctl_t;

endpackage

// ===== src/smht_tables.sv =====
// position, dense id and free-link tables with registered reads
`timescale 1ns / 1ps

module smht_tables #(
  parameter int unsigned CAPACITY = smht_pkg::CapacityDefault,
  parameter int unsigned IdW      = $clog2(CAPACITY)
) (
  input  logic                    clk_i,
  input  smht_pkg::smht_mem_ctl_t ctl_i,
  input  logic [IdW-1:0]          pos_raddr_i,
  input  logic [IdW-1:0]          idp_raddr_i,
  input  logic [IdW-1:0]          nf_raddr_i,
  input  logic [IdW-1:0]          pos_waddr_i,
  input  logic [IdW:0]            pos_wdata_i,
  input  logic [IdW-1:0]          idp_waddr_i,
  input  logic [IdW-1:0]          idp_wdata_i,
  input  logic [IdW-1:0]          nf_waddr_i,
  input  logic [IdW:0]            nf_wdata_i,
  output logic [IdW:0]            pos_rdata_o,
  output logic [IdW-1:0]          idp_rdata_o,
  output logic [IdW:0]            nf_rdata_o
);
  import smht_pkg::*;

  // valid bit on top, dense position below
  logic [IdW:0]   pos_mem [CAPACITY];
  logic [IdW-1:0] idp_mem [CAPACITY];
  logic [IdW:0]   nf_mem  [CAPACITY];

  smht_mem_ctl_t ctl;
  assign ctl = ctl_i;

  always_ff @(posedge clk_i) begin
    if (ctl.pos_we) begin
      pos_mem[pos_waddr_i] <= pos_wdata_i;
    end
    if (ctl.idp_we) begin
      idp_mem[idp_waddr_i] <= idp_wdata_i;
    end
    if (ctl.nf_we) begin
      nf_mem[nf_waddr_i] <= nf_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.rd_en) begin
      pos_rdata_o <= pos_mem[pos_raddr_i];
      idp_rdata_o <= idp_mem[idp_raddr_i];
      nf_rdata_o  <= nf_mem[nf_raddr_i];
    end
  end

endmodule

// ===== src/slot_map_handle_table_core.sv =====
// slot map handle table top level: request sequencer, table state and result register
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   request  | in_valid_i/in_ready_o | in_req_i  (req_type, slot_id)
//   result   | out_valid_o/out_ready_i | out_rsp_o (status, result_id, dense_pos,
//            |                       |            live_count)
//
// after reset a clearing pass sets up the position and free-link tables;
// no item is taken until it is done
// an item is taken only while the sequencer is idle: create goes through SCreate,
// lookup through SProbe, remove through SProbe then SRelease, set by the single write
// port of the position table (remove writes it twice: moved entry, then the freed id)
// one result register sits on the output; a held result stalls the sequencer
// in its answering step, and nothing is written until the result can go
`timescale 1ns / 1ps

module slot_map_handle_table_core #(
  parameter int unsigned CAPACITY = smht_pkg::CapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smht_pkg::smht_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output smht_pkg::smht_rsp_t out_rsp_o
);
  import smht_pkg::*;

  localparam int unsigned IdW  = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SCreate,
    SProbe,
    SRelease
  } state_e;

  state_e        state_q, state_d;
  logic [IdW-1:0] clr_q, clr_d;
  smht_req_t     req_q, req_d;
  logic          id_ok_q, id_ok_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdW:0]  head_q, head_d;     // may point one past the last id: list empty
  logic [IdW-1:0] tail_q, tail_d;
  logic [IdW-1:0] hole_q, hole_d;
  logic          out_valid_q, out_valid_d;
  smht_rsp_t     out_rsp_q, out_rsp_d;

  // table ports
  smht_mem_ctl_t  mem_ctl;
  logic [IdW-1:0] pos_raddr, idp_raddr, nf_raddr;
  logic [IdW-1:0] pos_waddr, idp_waddr, idp_wdata, nf_waddr;
  logic [IdW:0]   pos_wdata, nf_wdata;
  logic [IdW:0]   pos_rdata, nf_rdata;
  logic [IdW-1:0] idp_rdata;

  logic           in_fire, out_free;
  logic           full, hit, list_empty;
  logic [IdW-1:0] req_idx;

  assign in_ready_o = (state_q == SIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  // result register empty now or emptied at this edge
  assign out_free   = !out_valid_q || out_ready_i;
  assign req_idx    = IdW'(req_q.slot_id);

  assign full       = (count_q == CntW'(CAPACITY)) || (32'(head_q) >= CAPACITY);
  assign hit        = id_ok_q && pos_rdata[IdW];
  assign list_empty = (count_q == CntW'(CAPACITY));

  // all reads start together when the item is taken
  assign pos_raddr = IdW'(in_req_i.slot_id);
  assign idp_raddr = IdW'(count_q - CntW'(1));
  assign nf_raddr  = head_q[IdW-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    id_ok_d     = id_ok_q;
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    hole_d      = hole_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;

    mem_ctl   = '0;
    pos_waddr = req_idx;
    pos_wdata = '0;
    idp_waddr = hole_q;
    idp_wdata = '0;
    nf_waddr  = tail_q;
    nf_wdata  = '0;

    unique case (state_q)
      SClear: begin
        // every id invalid, free links chained in id order
        mem_ctl.pos_we = 1'b1;
        mem_ctl.nf_we  = 1'b1;
        pos_waddr      = clr_q;
        pos_wdata      = '0;
        nf_waddr       = clr_q;
        nf_wdata       = {1'b0, clr_q} + (IdW + 1)'(1);
        clr_d          = clr_q + IdW'(1);
        if (clr_q == IdW'(CAPACITY - 1)) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        if (in_fire) begin
          mem_ctl.rd_en = 1'b1;
          req_d         = in_req_i;
          id_ok_d       = (32'(in_req_i.slot_id) < CAPACITY);
          state_d       = (in_req_i.req_type == ReqCreate) ? SCreate : SProbe;
        end
      end

      SCreate: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = SIdle;
          if (full) begin
            out_rsp_d.status     = StatusFull;
            out_rsp_d.result_id  = '0;
            out_rsp_d.dense_pos  = '0;
            out_rsp_d.live_count = LiveCntW'(count_q);
          end else begin
            // head id goes to the end of the dense array
            mem_ctl.pos_we       = 1'b1;
            mem_ctl.idp_we       = 1'b1;
            pos_waddr            = head_q[IdW-1:0];
            pos_wdata            = {1'b1, IdW'(count_q)};
            idp_waddr            = IdW'(count_q);
            idp_wdata            = head_q[IdW-1:0];
            head_d               = nf_rdata;
            count_d              = count_q + CntW'(1);
            out_rsp_d.status     = StatusOk;
            out_rsp_d.result_id  = SlotIdW'(head_q);
            out_rsp_d.dense_pos  = DensePosW'(count_q);
            out_rsp_d.live_count = LiveCntW'(count_q + CntW'(1));
          end
        end
      end

      SProbe: begin
        if (out_free) begin
          if (req_q.req_type == ReqRemove) begin
            if (!hit || count_q == '0) begin
              out_valid_d          = 1'b1;
              out_rsp_d.status     = StatusRemoveMiss;
              out_rsp_d.result_id  = req_q.slot_id;
              out_rsp_d.dense_pos  = '0;
              out_rsp_d.live_count = LiveCntW'(count_q);
              state_d              = SIdle;
            end else begin
              // last dense entry moves into the hole
              mem_ctl.pos_we = 1'b1;
              mem_ctl.idp_we = 1'b1;
              pos_waddr      = idp_rdata;
              pos_wdata      = {1'b1, pos_rdata[IdW-1:0]};
              idp_waddr      = pos_rdata[IdW-1:0];
              idp_wdata      = idp_rdata;
              hole_d         = pos_rdata[IdW-1:0];
              // freed id joins the tail of the free list
              if (list_empty) begin
                head_d = {1'b0, req_idx};
              end else begin
                mem_ctl.nf_we = 1'b1;
                nf_waddr      = tail_q;
                nf_wdata      = {1'b0, req_idx};
              end
              tail_d  = req_idx;
              count_d = count_q - CntW'(1);
              state_d = SRelease;
            end
          end else begin
            // lookup, and the unused code acts the same
            out_valid_d          = 1'b1;
            out_rsp_d.result_id  = req_q.slot_id;
            out_rsp_d.live_count = LiveCntW'(count_q);
            if (hit) begin
              out_rsp_d.status    = StatusOk;
              out_rsp_d.dense_pos = DensePosW'(pos_rdata[IdW-1:0]);
            end else begin
              out_rsp_d.status    = StatusLookupMiss;
              out_rsp_d.dense_pos = '0;
            end
            state_d = SIdle;
          end
        end
      end

      SRelease: begin
        if (out_free) begin
          // cleared last so a removed tail entry ends invalid
          mem_ctl.pos_we       = 1'b1;
          pos_waddr            = req_idx;
          pos_wdata            = '0;
          out_valid_d          = 1'b1;
          out_rsp_d.status     = StatusOk;
          out_rsp_d.result_id  = req_q.slot_id;
          out_rsp_d.dense_pos  = DensePosW'(hole_q);
          out_rsp_d.live_count = LiveCntW'(count_q);
          state_d              = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      req_q       <= '0;
      id_ok_q     <= 1'b0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= IdW'(CAPACITY - 1);
      hole_q      <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      req_q       <= req_d;
      id_ok_q     <= id_ok_d;
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      hole_q      <= hole_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  smht_tables #(
    .CAPACITY (CAPACITY)
  ) u_tables (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .pos_raddr_i (pos_raddr),
    .idp_raddr_i (idp_raddr),
    .nf_raddr_i  (nf_raddr),
    .pos_waddr_i (pos_waddr),
    .pos_wdata_i (pos_wdata),
    .idp_waddr_i (idp_waddr),
    .idp_wdata_i (idp_wdata),
    .nf_waddr_i  (nf_waddr),
    .nf_wdata_i  (nf_wdata),
    .pos_rdata_o (pos_rdata),
    .idp_rdata_o (idp_rdata),
    .nf_rdata_o  (nf_rdata)
  );

endmodule

// ===== src/smht_checker.sv =====
// port-level checks of the handle table and their binding to the top level
`timescale 1ns / 1ps

`include "slot_map_handle_table_core_assert.svh"

module smht_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input smht_pkg::smht_rsp_t out_rsp_i
);
  import smht_pkg::*;

  logic out_stall, in_fire, rsp_err, rsp_full;

  assign out_stall = out_valid_i && !out_ready_i;
  assign in_fire   = in_valid_i && in_ready_i;
  assign rsp_err   = out_valid_i && (out_rsp_i.status != StatusOk);
  assign rsp_full  = out_valid_i && (out_rsp_i.status == StatusFull);

  // held result stays put
  `SMHT_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> (out_valid_i && $stable(out_rsp_i)))

  // one item at a time: busy right after an item is taken
  `SMHT_ASSERT(a_one_item, clk_i, rst_ni, in_fire |=> !in_ready_i)

  // every error result reports position zero
  `SMHT_ASSERT(a_err_pos, clk_i, rst_ni, rsp_err |-> (out_rsp_i.dense_pos == '0))

  // a full table hands out no id
  `SMHT_ASSERT(a_full_id, clk_i, rst_ni, rsp_full |-> (out_rsp_i.result_id == '0))

  // no result once reset has been seen at an edge
  `SMHT_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind slot_map_handle_table_core smht_checker u_smht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_i   (out_rsp_o)
);

// ===== sim/tb_slot_map_handle_table_core.sv =====
// self-checking testbench for the slot map handle table core
`timescale 1ns / 1ps

module tb_slot_map_handle_table_core;
  import smht_pkg::*;

  localparam int unsigned Capacity = CapacityDefault;
  // request code 3 has no name in the package; the block treats it as a lookup
  localparam logic [1:0] ReqLookupAlias = 2'd3;
  // cycles in which neither channel moves an item before the run is declared hung
  localparam int unsigned StallLimit = 4000;
  // long receiver hold-off used to fill the block and stall its input
  localparam int unsigned HoldOffCycles = 400;
  // settle time after the last expected result
  localparam int unsigned DrainCycles = 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  smht_req_t in_req_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  smht_rsp_t out_rsp_o;

  slot_map_handle_table_core #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // handle table predictor: own copy of the id index, dense array and free list
  // ---------------------------------------------------------------------------
  logic                 tbl_live  [Capacity];
  logic [DensePosW-1:0] tbl_pos   [Capacity];
  logic [LiveCntW-1:0]  tbl_next  [Capacity];
  logic [SlotIdW-1:0]   tbl_dense [Capacity];
  logic [LiveCntW-1:0]  tbl_count;
  logic [LiveCntW-1:0]  tbl_head;
  logic [SlotIdW-1:0]   tbl_tail;

  smht_rsp_t   rsp_expect_q[$];
  int unsigned fail_cnt = 0;

  // idling knobs, in percent per cycle
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_left = 0;

  function automatic void clear_table();
    for (int i = 0; i < Capacity; i++) begin
      tbl_live[i] = 1'b0;
      tbl_pos[i]  = '0;
      tbl_next[i] = LiveCntW'(i + 1);
      tbl_dense[i] = '0;
    end
    tbl_count = '0;
    tbl_head  = '0;
    tbl_tail  = SlotIdW'(Capacity - 1);
  endfunction

  // applies one request to the predicted table and returns the result it gives
  function automatic smht_rsp_t apply_request(smht_req_t r);
    smht_rsp_t            rsp;
    logic [SlotIdW-1:0]   id;
    logic [SlotIdW-1:0]   nid;
    logic [SlotIdW-1:0]   moved;
    logic [DensePosW-1:0] hole;
    logic [DensePosW-1:0] last;
    logic                 list_empty;
    rsp = '0;
    id  = r.slot_id;
    case (r.req_type)
      ReqCreate: begin
        if (tbl_count >= Capacity || tbl_head >= Capacity) begin
          // table full: id and position stay zero, nothing changes
          rsp.status = StatusFull;
        end else begin
          nid = tbl_head[SlotIdW-1:0];
          tbl_head = tbl_next[nid];
          tbl_live[nid] = 1'b1;
          tbl_pos[nid] = tbl_count[DensePosW-1:0];
          tbl_dense[tbl_count[DensePosW-1:0]] = nid;
          rsp.status = StatusOk;
          rsp.result_id = nid;
          rsp.dense_pos = tbl_count[DensePosW-1:0];
          tbl_count = tbl_count + 1'b1;
        end
      end
      ReqRemove: begin
        rsp.result_id = id;
        if (!tbl_live[id] || tbl_count == 0) begin
          rsp.status = StatusRemoveMiss;
        end else begin
          // free list is empty exactly when the table is full
          list_empty = (tbl_count >= Capacity);
          hole  = tbl_pos[id];
          last  = DensePosW'(tbl_count - 1'b1);
          moved = tbl_dense[last];
          tbl_dense[hole] = moved;
          tbl_live[moved] = 1'b1;
          tbl_pos[moved]  = hole;
          tbl_live[id]    = 1'b0;
          tbl_count = tbl_count - 1'b1;
          if (list_empty) begin
            tbl_head = LiveCntW'(id);
          end else begin
            tbl_next[tbl_tail] = LiveCntW'(id);
          end
          tbl_tail = id;
          rsp.status = StatusOk;
          rsp.dense_pos = hole;
        end
      end
      default: begin
        // lookup, and the unnamed code that behaves as one
        rsp.result_id = id;
        if (!tbl_live[id]) begin
          rsp.status = StatusLookupMiss;
        end else begin
          rsp.status = StatusOk;
          rsp.dense_pos = tbl_pos[id];
        end
      end
    endcase
    rsp.live_count = tbl_count;
    return rsp;
  endfunction

  // a live id picked at random, or any id while the table is empty
  function automatic logic [SlotIdW-1:0] pick_live_id();
    if (tbl_count == 0) return SlotIdW'($urandom_range(Capacity - 1));
    return tbl_dense[$urandom_range(tbl_count - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // request side: offers one item, keeps valid up until the handshake
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [SlotIdW-1:0] id);
    smht_req_t r;
    r.req_type = op;
    r.slot_id  = id;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rsp_expect_q.push_back(apply_request(r));
  endtask

  // drops valid and lets every expected result arrive, leaving the block idle
  task automatic close_phase();
    in_valid_i <= 1'b0;
    while (rsp_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, optional long hold-off, field checks
  // ---------------------------------------------------------------------------
  task automatic check_result(input smht_rsp_t got);
    smht_rsp_t want;
    if (rsp_expect_q.size() == 0) begin
      $error("result with no item pending: status %0d id %0d pos %0d count %0d",
             got.status, got.result_id, got.dense_pos, got.live_count);
      fail_cnt++;
      return;
    end
    want = rsp_expect_q.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      fail_cnt++;
    end
    if (got.result_id !== want.result_id) begin
      $error("result_id: expected %0d, actual %0d", want.result_id, got.result_id);
      fail_cnt++;
    end
    if (got.dense_pos !== want.dense_pos) begin
      $error("dense_pos: expected %0d, actual %0d", want.dense_pos, got.dense_pos);
      fail_cnt++;
    end
    if (got.live_count !== want.live_count) begin
      $error("live_count: expected %0d, actual %0d", want.live_count, got.live_count);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_rsp_o);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // hang detection: cycles in which neither channel moves an item
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty table misses, first creates, swap-with-last removal, code 3
  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_request(ReqLookup, 8'd0);
    send_request(ReqLookup, 8'd255);
    send_request(ReqRemove, 8'd0);       // remove on an empty table
    send_request(ReqRemove, 8'd255);
    send_request(ReqLookupAlias, 8'd7);
    send_request(ReqCreate, 8'd255);     // slot id is ignored on create
    send_request(ReqCreate, 8'd0);
    send_request(ReqCreate, 8'hA5);
    send_request(ReqLookup, 8'd0);
    send_request(ReqLookup, 8'd1);
    send_request(ReqLookup, 8'd2);
    send_request(ReqLookupAlias, 8'd1);
    send_request(ReqRemove, 8'd0);       // last entry moves into the hole
    send_request(ReqLookup, 8'd2);
    send_request(ReqRemove, 8'd0);       // id no longer live
    send_request(ReqRemove, 8'd2);
    send_request(ReqRemove, 8'd1);       // only entry, moves onto itself
    send_request(ReqLookup, 8'd1);
    send_request(ReqCreate, 8'h5A);
    send_request(ReqLookupAlias, 8'd3);
    close_phase();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = HoldOffCycles;
    repeat (12) begin
      case ($urandom_range(3))
        0: send_request(ReqCreate, SlotIdW'($urandom));
        1: send_request(ReqRemove, pick_live_id());
        2: send_request(ReqLookup, pick_live_id());
        default: send_request(ReqLookupAlias, SlotIdW'($urandom));
      endcase
    end
    close_phase();
  endtask

  // mostly creates until the table is full, then full and empty free list cases
  task automatic test_fill_to_full();
    int unsigned pick;
    src_idle_pct = 88;
    sink_stall_pct = 0;
    while (tbl_count < Capacity) begin
      pick = $urandom_range(99);
      if (pick < 88) send_request(ReqCreate, SlotIdW'($urandom));
      else if (pick < 95) send_request(ReqLookup, pick_live_id());
      else if (pick < 98) send_request(ReqRemove, pick_live_id());
      else send_request(ReqLookupAlias, SlotIdW'($urandom));
    end
    repeat (3) send_request(ReqCreate, SlotIdW'($urandom));
    // removal with an empty free list makes the freed id the new head
    send_request(ReqRemove, pick_live_id());
    send_request(ReqCreate, SlotIdW'($urandom));
    send_request(ReqCreate, SlotIdW'($urandom));
    send_request(ReqRemove, pick_live_id());
    send_request(ReqRemove, pick_live_id());
    send_request(ReqLookup, pick_live_id());
    repeat (3) send_request(ReqCreate, SlotIdW'($urandom));
    close_phase();
  endtask

  // removal heavy traffic with a slow receiver
  task automatic test_drain();
    int unsigned pick;
    src_idle_pct = 0;
    sink_stall_pct = 88;
    repeat (120) begin
      pick = $urandom_range(99);
      if (pick < 65) send_request(ReqRemove, pick_live_id());
      else if (pick < 75) send_request(ReqRemove, SlotIdW'($urandom));
      else if (pick < 85) send_request(ReqLookup, SlotIdW'($urandom));
      else if (pick < 95) send_request(ReqCreate, SlotIdW'($urandom));
      else send_request(ReqLookup, pick_live_id());
    end
    close_phase();
  endtask

  // balanced mix with light idling on both sides
  task automatic test_mixed_traffic();
    int unsigned pick;
    src_idle_pct = 15;
    sink_stall_pct = 15;
    repeat (90) begin
      pick = $urandom_range(99);
      if (pick < 35) send_request(ReqCreate, SlotIdW'($urandom));
      else if (pick < 65) send_request(ReqRemove, pick_live_id());
      else if (pick < 75) send_request(ReqRemove, SlotIdW'($urandom));
      else if (pick < 90) send_request(ReqLookup, pick_live_id());
      else if (pick < 95) send_request(ReqLookup, SlotIdW'($urandom));
      else send_request(ReqLookupAlias, pick_live_id());
    end
    close_phase();
  endtask

  initial begin
    clear_table();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_fill_to_full();
    test_drain();
    test_mixed_traffic();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/smht_pkg.sv
src/smht_tables.sv
src/slot_map_handle_table_core.sv
src/smht_checker.sv
sim/tb_slot_map_handle_table_core.sv
